FILE: design/assert_macros.svh
// Assertion macros shared by the slerp RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define QSL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define QSL_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: design/qsl_pkg.sv
// Shared constants, types and the arctangent table for the slerp pipeline.
// No dependencies.
package qsl_pkg;

    localparam int ANG_W   = 34;
    localparam int TAB_LEN = 24;
    localparam int SQ_IN_W = 61;
    localparam int SQ_W    = 31;
    localparam int ONE_Q30  = 1073741824;
    localparam int NEAR_EPS = 1074;
    localparam logic signed [15:0] T_ONE = 16'sd16384;
    localparam logic [31:0] DIV_K_REM0 = 32'h1000_0000;

    localparam logic [1:0] PATH_SPH  = 2'd0;
    localparam logic [1:0] PATH_LIN  = 2'd1;
    localparam logic [1:0] PATH_END  = 2'd2;
    localparam logic [1:0] PATH_NONE = 2'd3;

    typedef struct packed {
        logic en;
        logic vld;
    } stg_ctl_t;

    // atan(2^-i) in Q.30 radians
    function automatic logic signed [ANG_W-1:0] atan_q30(input int unsigned idx);
        logic signed [ANG_W-1:0] r;
        case (idx)
            0:  r = 34'sh0_3243F6A8;
            1:  r = 34'sh0_1DAC6705;
            2:  r = 34'sh0_0FADBAFC;
            3:  r = 34'sh0_07F56EA6;
            4:  r = 34'sh0_03FEAB76;
            5:  r = 34'sh0_01FFD55B;
            6:  r = 34'sh0_00FFFAAA;
            7:  r = 34'sh0_007FFF55;
            8:  r = 34'sh0_003FFFEA;
            9:  r = 34'sh0_001FFFFD;
            10: r = 34'sh0_000FFFFF;
            11: r = 34'sh0_0007FFFF;
            12: r = 34'sh0_0003FFFF;
            13: r = 34'sh0_0001FFFF;
            14: r = 34'sh0_0000FFFF;
            15: r = 34'sh0_00007FFF;
            16: r = 34'sh0_00003FFF;
            17: r = 34'sh0_00001FFF;
            18: r = 34'sh0_00000FFF;
            19: r = 34'sh0_000007FF;
            20: r = 34'sh0_000003FF;
            21: r = 34'sh0_000001FF;
            22: r = 34'sh0_000000FF;
            23: r = 34'sh0_0000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: design/qsl_isqrt.sv
// Pipelined integer square root, one result bit per stage, word carried alongside.
// Depends on qsl_pkg.
module qsl_isqrt import qsl_pkg::*; #(
    parameter int SW = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  stg_ctl_t           ctl,
    input  logic [SQ_IN_W-1:0] v_in,
    input  logic [SW-1:0]      side_in,
    output logic               out_valid,
    output logic [SQ_W-1:0]    root,
    output logic [SW-1:0]      side_out
);

    logic               vld_reg  [SQ_W];
    logic [SQ_IN_W-1:0] rem_reg  [SQ_W];
    logic [SQ_W-1:0]    root_reg [SQ_W];
    logic [SW-1:0]      side_reg [SQ_W];

    for (genvar g = 0; g < SQ_W; g++) begin : g_stage
        localparam int BIT = SQ_W - 1 - g;
        logic               vi;
        logic [SQ_IN_W-1:0] remi;
        logic [SQ_W-1:0]    rooti;
        logic [SW-1:0]      si;
        logic [SQ_IN_W+1:0] trial;
        logic [SQ_IN_W-1:0] rem_next;
        logic [SQ_W-1:0]    root_next;

        if (g == 0) begin : g_first
            assign vi    = ctl.vld;
            assign remi  = v_in;
            assign rooti = '0;
            assign si    = side_in;
        end else begin : g_rest
            assign vi    = vld_reg[g-1];
            assign remi  = rem_reg[g-1];
            assign rooti = root_reg[g-1];
            assign si    = side_reg[g-1];
        end

        always_comb
        begin
            trial = ((SQ_IN_W+2)'(rooti) << (BIT + 1)) | ((SQ_IN_W+2)'(1) << (2 * BIT));
            if ({2'b00, remi} >= trial)
            begin
                rem_next  = remi - trial[SQ_IN_W-1:0];
                root_next = rooti | (SQ_W'(1) << BIT);
            end
            else
            begin
                rem_next  = remi;
                root_next = rooti;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ctl.en)
                vld_reg[g] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[g]  <= rem_next;
                root_reg[g] <= root_next;
                side_reg[g] <= si;
            end
        end
    end

    assign out_valid = vld_reg[SQ_W-1];
    assign root      = root_reg[SQ_W-1];
    assign side_out  = side_reg[SQ_W-1];

endmodule

FILE: design/qsl_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on qsl_pkg. Caller guarantees rem_in < dvs_in.
module qsl_div import qsl_pkg::*; #(
    parameter int DW = 32,
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  stg_ctl_t      ctl,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] low_in,
    input  logic [DW-1:0] dvs_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic          vld_reg  [QW];
    logic [DW-1:0] rem_reg  [QW];
    logic [QW-1:0] low_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [DW-1:0] dvs_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic          vi;
        logic [DW-1:0] remi;
        logic [QW-1:0] lowi;
        logic [QW-1:0] quoi;
        logic [DW-1:0] dvsi;
        logic [SW-1:0] si;
        logic [DW:0]   r2;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (g == 0) begin : g_first
            assign vi   = ctl.vld;
            assign remi = rem_in;
            assign lowi = low_in;
            assign quoi = '0;
            assign dvsi = dvs_in;
            assign si   = side_in;
        end else begin : g_rest
            assign vi   = vld_reg[g-1];
            assign remi = rem_reg[g-1];
            assign lowi = low_reg[g-1];
            assign quoi = quo_reg[g-1];
            assign dvsi = dvs_reg[g-1];
            assign si   = side_reg[g-1];
        end

        always_comb
        begin
            r2 = {remi, lowi[QW-1]};
            if (r2 >= {1'b0, dvsi})
            begin
                rem_next = DW'(r2 - {1'b0, dvsi});
                quo_next = {quoi[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = r2[DW-1:0];
                quo_next = {quoi[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ctl.en)
                vld_reg[g] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                rem_reg[g]  <= rem_next;
                low_reg[g]  <= lowi << 1;
                quo_reg[g]  <= quo_next;
                dvs_reg[g]  <= dvsi;
                side_reg[g] <= si;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: design/qsl_cordic.sv
// Pipelined CORDIC, one micro-rotation per stage, vectoring or rotation mode.
// Depends on qsl_pkg for the arctangent table.
module qsl_cordic import qsl_pkg::*; #(
    parameter int STAGES = 16,
    parameter bit VECTOR = 1'b0,
    parameter int SW     = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  stg_ctl_t                ctl,
    input  logic signed [ANG_W-1:0] x_in,
    input  logic signed [ANG_W-1:0] y_in,
    input  logic signed [ANG_W-1:0] z_in,
    input  logic [SW-1:0]           side_in,
    output logic                    out_valid,
    output logic signed [ANG_W-1:0] x_out,
    output logic signed [ANG_W-1:0] y_out,
    output logic signed [ANG_W-1:0] z_out,
    output logic [SW-1:0]           side_out
);

    logic                    vld_reg  [STAGES];
    logic signed [ANG_W-1:0] x_reg    [STAGES];
    logic signed [ANG_W-1:0] y_reg    [STAGES];
    logic signed [ANG_W-1:0] z_reg    [STAGES];
    logic [SW-1:0]           side_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic                    vi;
        logic signed [ANG_W-1:0] xi, yi, zi, dx, dy, at;
        logic signed [ANG_W-1:0] x_next, y_next, z_next;
        logic [SW-1:0]           si;
        logic                    cw;

        if (g == 0) begin : g_first
            assign vi = ctl.vld;
            assign xi = x_in;
            assign yi = y_in;
            assign zi = z_in;
            assign si = side_in;
        end else begin : g_rest
            assign vi = vld_reg[g-1];
            assign xi = x_reg[g-1];
            assign yi = y_reg[g-1];
            assign zi = z_reg[g-1];
            assign si = side_reg[g-1];
        end

        assign dx = yi >>> g;
        assign dy = xi >>> g;
        assign at = atan_q30(g);
        assign cw = VECTOR ? (yi >= 0) : (zi < 0);

        always_comb
        begin
            if (cw)
            begin
                x_next = xi + dx;
                y_next = yi - dy;
                z_next = zi + at;
            end
            else
            begin
                x_next = xi - dx;
                y_next = yi + dy;
                z_next = zi - at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (ctl.en)
                vld_reg[g] <= vi;
        end

        always_ff @(posedge clk)
        begin
            if (ctl.en)
            begin
                x_reg[g]    <= x_next;
                y_reg[g]    <= y_next;
                z_reg[g]    <= z_next;
                side_reg[g] <= si;
            end
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign x_out     = x_reg[STAGES-1];
    assign y_out     = y_reg[STAGES-1];
    assign z_out     = z_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule

FILE: design/quaternion_slerp_top.sv
// Quaternion slerp, fully pipelined top level.
// Depends on qsl_pkg, qsl_isqrt, qsl_div, qsl_cordic and assert_macros.svh.
//
// Input channel item_valid/item_stall carries one word: two Q1.15 quaternions
// and a Q2.14 blend factor. Output channel result_valid/result_stall returns
// one word per input: the interpolated Q1.15 quaternion and the path code.
// A word moves when valid is high and stall is low at a rising edge.
// Stages in order: dot product, 31-stage square root, vectoring CORDIC,
// 32-stage reciprocal of the CORDIC gain, two rotation CORDICs, two 31-stage
// weight dividers, then the blend.
// A new word is taken every cycle while item_stall is low; throughput is one word per cycle.
// All stages move together. When the output register holds a word the
// receiver stalls and the last stage is also full, the pipeline freezes and
// item_stall rises; a bubble at the tail is squeezed out instead.
// Reset clears every valid bit; no word is in flight after reset.
`include "assert_macros.svh"

module quaternion_slerp_top import qsl_pkg::*; #(
    parameter int COMPONENT_BITS = 16,
    parameter int ANGLE_STAGES   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic signed [15:0] from_x,
    input  logic signed [15:0] from_y,
    input  logic signed [15:0] from_z,
    input  logic signed [15:0] from_w,
    input  logic signed [15:0] to_x,
    input  logic signed [15:0] to_y,
    input  logic signed [15:0] to_z,
    input  logic signed [15:0] to_w,
    input  logic signed [15:0] blend_t,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [15:0] out_x,
    output logic signed [15:0] out_y,
    output logic signed [15:0] out_z,
    output logic signed [15:0] out_w,
    output logic [1:0]         path_taken
);

    localparam int CW  = COMPONENT_BITS + 1;
    localparam int PW  = 2 * CW;
    localparam int SH  = 2 * (COMPONENT_BITS - 1) - 30;
    localparam int SHR = (SH >= 0) ? SH : 0;
    localparam int SHL = (SH < 0) ? -SH : 0;
    localparam int NST = (ANGLE_STAGES < TAB_LEN) ? ANGLE_STAGES : TAB_LEN;
    localparam int PAW = 32 + CW;
    localparam int AW  = PAW + 1;
    localparam logic signed [AW-1:0] RND    = AW'(1) << 29;
    localparam logic signed [AW-1:0] LIM_HI = (AW'(1) << (COMPONENT_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] LIM_LO = -(AW'(1) << (COMPONENT_BITS - 1));

    typedef struct packed {
        logic [3:0][CW-1:0] a;
        logic [3:0][CW-1:0] b;
        logic signed [15:0] t;
        logic [1:0]         path;
        logic               sel_a;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    function automatic logic [CW-1:0] ext_comp(input logic [15:0] f);
        logic [47:0] fz;
        fz = 48'(f);
        return {fz[COMPONENT_BITS-1], fz[COMPONENT_BITS-1:0]};
    endfunction

    function automatic logic signed [ANG_W-1:0] to_q30(input logic signed [PW-1:0] p);
        logic signed [71:0] pe;
        pe = 72'(p);
        pe = (pe >>> SHR) <<< SHL;
        return ANG_W'(pe);
    endfunction

    logic en;
    logic f2_vld_reg;
    logic res_valid_reg;

    assign en         = !(res_valid_reg && result_stall && f2_vld_reg);
    assign item_stall = !en;

    // stage 1: extend, special cases, dot product terms
    logic [3:0][15:0]         fa, fb;
    ctx_t                     s1_ctx_next, s1_ctx_reg;
    logic signed [PW-1:0]     s1_prod_next [4];
    logic signed [PW-1:0]     s1_prod_reg  [4];
    logic                     s1_vld_reg;
    logic                     same;

    assign fa = {from_w, from_z, from_y, from_x};
    assign fb = {to_w, to_z, to_y, to_x};

    always_comb
    begin
        same = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            s1_ctx_next.a[i] = ext_comp(fa[i]);
            s1_ctx_next.b[i] = ext_comp(fb[i]);
            if (s1_ctx_next.a[i] != s1_ctx_next.b[i])
                same = 1'b0;
            s1_prod_next[i] = PW'(signed'(s1_ctx_next.a[i])) * PW'(signed'(s1_ctx_next.b[i]));
        end
        s1_ctx_next.t     = blend_t;
        s1_ctx_next.sel_a = (blend_t <= 16'sd0);
        s1_ctx_next.path  = ((blend_t <= 16'sd0) || (blend_t >= T_ONE) || same) ?
                            PATH_END : PATH_SPH;
    end

    // stage 2: sum of products
    ctx_t                    s2_ctx_reg;
    logic signed [ANG_W-1:0] s2_c_reg;
    logic                    s2_vld_reg;

    // stage 3: fold sign, pick path
    ctx_t                    s3_ctx_next, s3_ctx_reg;
    logic [29:0]             s3_cc_reg;
    logic [ANG_W-1:0]        c_abs;
    logic signed [ANG_W:0]   c_gap;
    logic                    c_neg;
    logic                    s3_vld_reg;

    always_comb
    begin
        s3_ctx_next = s2_ctx_reg;
        c_neg = (s2_c_reg < 0) && (s2_ctx_reg.path != PATH_END);
        c_abs = (s2_c_reg < 0) ? ANG_W'(-s2_c_reg) : ANG_W'(s2_c_reg);
        c_gap = (ANG_W+1)'(ONE_Q30) - signed'({1'b0, c_abs});
        if (s2_ctx_reg.path != PATH_END)
            s3_ctx_next.path = (c_gap < (ANG_W+1)'(NEAR_EPS)) ? PATH_LIN : PATH_SPH;
        for (int i = 0; i < 4; i++)
        begin
            if (c_neg)
                s3_ctx_next.b[i] = CW'(-signed'(s2_ctx_reg.b[i]));
        end
    end

    // stage 4: 1 - c^2
    ctx_t               s4_ctx_reg;
    logic [29:0]        s4_cc_reg;
    logic [SQ_IN_W-1:0] s4_v_reg;
    logic               s4_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= item_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctx_reg  <= s1_ctx_next;
            s1_prod_reg <= s1_prod_next;
            s2_ctx_reg  <= s1_ctx_reg;
            s2_c_reg    <= to_q30(s1_prod_reg[0]) + to_q30(s1_prod_reg[1])
                         + to_q30(s1_prod_reg[2]) + to_q30(s1_prod_reg[3]);
            s3_ctx_reg  <= s3_ctx_next;
            s3_cc_reg   <= c_abs[29:0];
            s4_ctx_reg  <= s3_ctx_reg;
            s4_cc_reg   <= s3_cc_reg;
            s4_v_reg    <= (SQ_IN_W'(1) << 60) - SQ_IN_W'(s3_cc_reg * s3_cc_reg);
        end
    end

    // sin w
    logic              sq_vld;
    logic [SQ_W-1:0]   sq_root;
    logic [CTX_W+29:0] sq_side;
    ctx_t              sq_ctx;
    logic [29:0]       sq_cc;

    qsl_isqrt #(.SW(CTX_W + 30)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: s4_vld_reg}),
        .v_in     (s4_v_reg),
        .side_in  ({s4_ctx_reg, s4_cc_reg}),
        .out_valid(sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    assign {sq_ctx, sq_cc} = sq_side;

    // angle w
    logic                    vc_vld;
    logic signed [ANG_W-1:0] vc_x, vc_z;
    logic [CTX_W+SQ_W-1:0]   vc_side;
    ctx_t                    vc_ctx;
    logic [SQ_W-1:0]         vc_sinv;

    qsl_cordic #(.STAGES(NST), .VECTOR(1'b1), .SW(CTX_W + SQ_W)) u_vec (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: sq_vld}),
        .x_in     (signed'(ANG_W'(sq_cc))),
        .y_in     (signed'(ANG_W'(sq_root))),
        .z_in     ('0),
        .side_in  ({sq_ctx, sq_root}),
        .out_valid(vc_vld),
        .x_out    (vc_x),
        .y_out    (),
        .z_out    (vc_z),
        .side_out (vc_side)
    );

    assign {vc_ctx, vc_sinv} = vc_side;

    // w * t
    ctx_t                    m1_ctx_reg;
    logic [SQ_W-1:0]         m1_sinv_reg;
    logic signed [ANG_W-1:0] m1_x_reg, m1_z_reg;
    logic signed [49:0]      m1_zt_reg;
    logic                    m1_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_vld_reg <= 1'b0;
        else if (en)
            m1_vld_reg <= vc_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_ctx_reg  <= vc_ctx;
            m1_sinv_reg <= vc_sinv;
            m1_x_reg    <= vc_x;
            m1_z_reg    <= vc_z;
            m1_zt_reg   <= 50'(vc_z) * 50'(vc_ctx.t);
        end
    end

    logic signed [ANG_W-1:0] m1_a1, m1_a0;

    assign m1_a1 = ANG_W'(m1_zt_reg >>> 14);
    assign m1_a0 = m1_z_reg - m1_a1;

    // gain correction k = 2^60 / x
    localparam int KS_W = CTX_W + SQ_W + 2 * ANG_W + 1;

    logic                    kd_vld;
    logic [31:0]             kd_quo, kd_k;
    logic [KS_W-1:0]         kd_side;
    ctx_t                    kd_ctx;
    logic [SQ_W-1:0]         kd_sinv;
    logic signed [ANG_W-1:0] kd_a0, kd_a1;
    logic                    kd_xpos;

    qsl_div #(.DW(32), .QW(32), .SW(KS_W)) u_kdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: m1_vld_reg}),
        .rem_in   (DIV_K_REM0),
        .low_in   ('0),
        .dvs_in   (m1_x_reg[31:0]),
        .side_in  ({m1_ctx_reg, m1_sinv_reg, m1_a0, m1_a1, m1_x_reg > 0}),
        .out_valid(kd_vld),
        .quo      (kd_quo),
        .side_out (kd_side)
    );

    assign {kd_ctx, kd_sinv, kd_a0, kd_a1, kd_xpos} = kd_side;
    assign kd_k = kd_xpos ? kd_quo : '0;

    // sin((1-t)w) and sin(tw)
    logic                    r0_vld;
    logic signed [ANG_W-1:0] r0_s, r1_s;
    logic [CTX_W-1:0]        r0_side;
    logic [SQ_W-1:0]         r1_sinv;
    ctx_t                    r0_ctx;

    qsl_cordic #(.STAGES(NST), .VECTOR(1'b0), .SW(CTX_W)) u_rot0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: kd_vld}),
        .x_in     (signed'(ANG_W'(kd_k))),
        .y_in     ('0),
        .z_in     (kd_a0),
        .side_in  (kd_ctx),
        .out_valid(r0_vld),
        .x_out    (),
        .y_out    (r0_s),
        .z_out    (),
        .side_out (r0_side)
    );

    qsl_cordic #(.STAGES(NST), .VECTOR(1'b0), .SW(SQ_W)) u_rot1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: kd_vld}),
        .x_in     (signed'(ANG_W'(kd_k))),
        .y_in     ('0),
        .z_in     (kd_a1),
        .side_in  (kd_sinv),
        .out_valid(),
        .x_out    (),
        .y_out    (r1_s),
        .z_out    (),
        .side_out (r1_sinv)
    );

    assign r0_ctx = r0_side;

    // weights s / sin w, magnitude division
    logic [SQ_W-1:0]  sv;
    logic [ANG_W-1:0] mag0, mag1;
    logic             neg0, neg1, ovf0, ovf1;

    always_comb
    begin
        sv   = (r1_sinv == '0) ? SQ_W'(1) : r1_sinv;
        neg0 = (r0_s < 0);
        neg1 = (r1_s < 0);
        mag0 = neg0 ? ANG_W'(-r0_s) : ANG_W'(r0_s);
        mag1 = neg1 ? ANG_W'(-r1_s) : ANG_W'(r1_s);
        ovf0 = ({1'b0, mag0} >= (ANG_W+1)'({sv, 1'b0}));
        ovf1 = ({1'b0, mag1} >= (ANG_W+1)'({sv, 1'b0}));
    end

    logic            wd_vld;
    logic [30:0]     wd0_quo, wd1_quo;
    logic [CTX_W+1:0] wd0_side;
    logic [1:0]      wd1_side;
    ctx_t            wd_ctx;
    logic            wd_neg0, wd_ovf0, wd_neg1, wd_ovf1;

    qsl_div #(.DW(SQ_W), .QW(31), .SW(CTX_W + 2)) u_wdiv0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: r0_vld}),
        .rem_in   (mag0[SQ_W:1]),
        .low_in   ({mag0[0], 30'b0}),
        .dvs_in   (sv),
        .side_in  ({r0_ctx, neg0, ovf0}),
        .out_valid(wd_vld),
        .quo      (wd0_quo),
        .side_out (wd0_side)
    );

    qsl_div #(.DW(SQ_W), .QW(31), .SW(2)) u_wdiv1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      ('{en: en, vld: r0_vld}),
        .rem_in   (mag1[SQ_W:1]),
        .low_in   ({mag1[0], 30'b0}),
        .dvs_in   (sv),
        .side_in  ({neg1, ovf1}),
        .out_valid(),
        .quo      (wd1_quo),
        .side_out (wd1_side)
    );

    assign {wd_ctx, wd_neg0, wd_ovf0} = wd0_side;
    assign {wd_neg1, wd_ovf1}         = wd1_side;

    // stage W2: final weights
    ctx_t               w2_ctx_reg;
    logic signed [31:0] w2_w0_reg, w2_w1_reg;
    logic signed [31:0] w0_next, w1_next;
    logic [30:0]        wm0, wm1;
    logic               w2_vld_reg;

    always_comb
    begin
        wm0 = wd_ovf0 ? 31'h7FFF_FFFF : wd0_quo;
        wm1 = wd_ovf1 ? 31'h7FFF_FFFF : wd1_quo;
        if (wd_ctx.path == PATH_LIN)
        begin
            w0_next = 32'(T_ONE - wd_ctx.t) <<< 16;
            w1_next = 32'(wd_ctx.t) <<< 16;
        end
        else
        begin
            w0_next = wd_neg0 ? -signed'({1'b0, wm0}) : signed'({1'b0, wm0});
            w1_next = wd_neg1 ? -signed'({1'b0, wm1}) : signed'({1'b0, wm1});
        end
    end

    // stage F1: products, stage F2: round, saturate, select
    ctx_t                 f1_ctx_reg;
    logic signed [PAW-1:0] f1_pa_reg [4];
    logic signed [PAW-1:0] f1_pb_reg [4];
    logic                 f1_vld_reg;
    logic [3:0][15:0]     f2_res_next, f2_res_reg;
    logic [1:0]           f2_path_reg;
    logic signed [AW-1:0] acc, rsh, rsat;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            acc  = AW'(f1_pa_reg[i]) + AW'(f1_pb_reg[i]) + RND;
            rsh  = acc >>> 30;
            rsat = (rsh > LIM_HI) ? LIM_HI : ((rsh < LIM_LO) ? LIM_LO : rsh);
            if (f1_ctx_reg.path == PATH_END)
                f2_res_next[i] = f1_ctx_reg.sel_a ? 16'(signed'(f1_ctx_reg.a[i]))
                                                  : 16'(signed'(f1_ctx_reg.b[i]));
            else
                f2_res_next[i] = 16'(rsat);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w2_vld_reg <= 1'b0;
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            w2_vld_reg <= wd_vld;
            f1_vld_reg <= w2_vld_reg;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w2_ctx_reg  <= wd_ctx;
            w2_w0_reg   <= w0_next;
            w2_w1_reg   <= w1_next;
            f1_ctx_reg  <= w2_ctx_reg;
            for (int i = 0; i < 4; i++)
            begin
                f1_pa_reg[i] <= PAW'(w2_w0_reg) * PAW'(signed'(w2_ctx_reg.a[i]));
                f1_pb_reg[i] <= PAW'(w2_w1_reg) * PAW'(signed'(w2_ctx_reg.b[i]));
            end
            f2_res_reg  <= f2_res_next;
            f2_path_reg <= f1_ctx_reg.path;
        end
    end

    // output register
    logic [3:0][15:0] res_reg;
    logic [1:0]       res_path_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (!res_valid_reg || !result_stall)
            res_valid_reg <= f2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (!res_valid_reg || !result_stall)
        begin
            res_reg      <= f2_res_reg;
            res_path_reg <= f2_path_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_x        = signed'(res_reg[0]);
    assign out_y        = signed'(res_reg[1]);
    assign out_z        = signed'(res_reg[2]);
    assign out_w        = signed'(res_reg[3]);
    assign path_taken   = res_path_reg;

    `QSL_ASSERT(a_take_when_empty, !res_valid_reg |-> !item_stall, "input stalled with empty output")
    `QSL_NEVER(a_no_spare_path, res_valid_reg && (res_path_reg == PATH_NONE), "unused path code")
    `QSL_ASSERT(a_freeze_full, (res_valid_reg && result_stall && f2_vld_reg) |=> (f2_vld_reg && $stable(f2_res_reg)), "tail word lost under stall")

endmodule
